/* sv/kss_pkg.sv */
// Shared constants, types and command/status structs for the key slot store search block.
// No dependencies; the controller, datapath and top level import this package.
`default_nettype none

package kss_pkg;

	localparam int SEGMENT_COUNT     = 9;
	localparam int SEGMENT_WORDS     = 256;
	localparam int SLOTS_PER_SEGMENT = 85;

	localparam int STORE_WORDS = SEGMENT_COUNT * SEGMENT_WORDS;
	// only slots that fit wholly after the tag word
	localparam int SLOT_LIMIT  = (SLOTS_PER_SEGMENT < (SEGMENT_WORDS - 1) / 3) ?
		SLOTS_PER_SEGMENT : (SEGMENT_WORDS - 1) / 3;

	localparam int WORD_W  = 16;
	localparam int ADDR_W  = $clog2(STORE_WORDS);
	localparam int OFF_W   = $clog2(SEGMENT_WORDS);
	localparam int SEG_IW  = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
	localparam int SLOT_IW = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1;

	localparam int IDX_W      = 12;
	localparam int SEG_OUT_W  = 4;
	localparam int SLOT_OUT_W = 7;

	localparam logic [WORD_W-1:0]  SEGMENT_TAG = 16'hC0DE;
	localparam logic [WORD_W-1:0]  ERASED_WORD = 16'hFFFF;
	localparam logic [SEG_IW-1:0]  LAST_SEG    = SEG_IW'(SEGMENT_COUNT - 1);
	localparam logic [SLOT_IW-1:0] LAST_SLOT   = SLOT_IW'(SLOT_LIMIT - 1);
	localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(STORE_WORDS - 1);
	localparam logic [ADDR_W-1:0]  SEG_STRIDE  = ADDR_W'(SEGMENT_WORDS);

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// position of a word within a segment scan
	typedef enum logic [1:0] {
		PH_TAG = 2'd0,
		PH_W0  = 2'd1,
		PH_W1  = 2'd2,
		PH_W2  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_FOUND = 2'd1,
		RES_END   = 2'd2
	} res_kind_t;

	typedef struct packed {
		logic      load;    // capture the accepted word, reset scan state
		logic      clear;   // one step of the erase pass
		logic      write;   // store the captured word
		logic      scan;    // issue the next read
		logic      skip;    // drop the in-flight read, jump to next segment
		logic      record;  // remember the evaluated slot as first free
		logic      finish;  // latch a result
		res_kind_t kind;
	} kss_cmd_t;

	typedef struct packed {
		logic eval_v;
		logic eval_tag;
		logic tag_hit;
		logic slot_end;
		logic match;
		logic free_new;
		logic last_slot;
		logic last_seg;
		logic clear_last;
	} kss_stat_t;

endpackage

`default_nettype wire

/* sv/key_slot_store_search.sv */
// Top level of the key slot store search block: controller plus datapath.
// Depends on kss_pkg, kss_ctl, kss_dp (and kss_ram through kss_dp).
`default_nettype none

// A 2304-word store (nine segments of 256 words) erased to 0xFFFF. After reset the
// block erases the whole store with busy high; then a word is taken when start is
// high and busy is low. A write word is stored in the state after accept and gives
// an all-zero result. A search reads the single store port one word per cycle,
// pausing when it skips to the next segment: a tagged segment is read up to its end
// or the first free slot of the search, an untagged one only up to its tag word.
// The result is shown for one cycle with done high and cannot be held off by the
// receiver; busy stays high until then.
module key_slot_store_search
	import kss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire logic                  cmd,
	input  wire logic [IDX_W-1:0]      word_index,
	input  wire logic [WORD_W-1:0]     write_value,
	input  wire logic [WORD_W-1:0]     key_first,
	input  wire logic [WORD_W-1:0]     key_second,
	input  wire logic [WORD_W-1:0]     key_third,
	output      logic                  done,
	output      logic                  found,
	output      logic                  has_place,
	output      logic [SEG_OUT_W-1:0]  segment_number,
	output      logic [SLOT_OUT_W-1:0] slot_number
);

	kss_cmd_t  ctl;
	kss_stat_t st;

	kss_ctl u_ctl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.st    (st),
		.ctl   (ctl),
		.busy  (busy),
		.done  (done)
	);

	kss_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.st            (st),
		.word_index    (word_index),
		.write_value   (write_value),
		.key_first     (key_first),
		.key_second    (key_second),
		.key_third     (key_third),
		.found         (found),
		.has_place     (has_place),
		.segment_number(segment_number),
		.slot_number   (slot_number)
	);

endmodule

`default_nettype wire

/* sv/kss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/kss_ctl.sv */
// Controller FSM: erase pass, write and search sequencing, result strobe.
// Depends on kss_pkg.
`default_nettype none

module kss_ctl
	import kss_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      cmd,
	input  wire kss_stat_t st,
	output kss_cmd_t       ctl,
	output logic           busy,
	output logic           done
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WRITE,
		S_SCAN
	} state_t;

	state_t state_q, state_n;
	logic   busy_q, done_q;
	logic   hit, free, miss, last_word;

	assign busy = busy_q;
	assign done = done_q;

	always_comb begin
		ctl     = '0;
		ctl.kind = RES_ZERO;
		state_n = state_q;
		hit       = st.eval_v && st.slot_end && st.match;
		free      = st.eval_v && st.slot_end && !st.match && st.free_new;
		miss      = st.eval_v && st.eval_tag && !st.tag_hit;
		last_word = st.eval_v && st.slot_end && st.last_slot && st.last_seg;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clear = 1'b1;
				if (st.clear_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start && !busy_q) begin
					ctl.load = 1'b1;
					state_n  = (cmd == CMD_SEARCH) ? S_SCAN : S_WRITE;
				end
			end
			S_WRITE: begin
				ctl.write  = 1'b1;
				ctl.finish = 1'b1;
				ctl.kind   = RES_ZERO;
				state_n    = S_IDLE;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (hit) begin
					ctl.finish = 1'b1;
					ctl.kind   = RES_FOUND;
					state_n    = S_IDLE;
				end else begin
					ctl.record = free;
					if (((free || miss) && st.last_seg) || last_word) begin
						ctl.finish = 1'b1;
						ctl.kind   = RES_END;
						state_n    = S_IDLE;
					end else begin
						ctl.skip = free || miss;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			busy_q  <= (state_n != S_IDLE);
			done_q  <= ctl.finish;
		end
	end

endmodule

`default_nettype wire

/* sv/kss_dp.sv */
// Datapath: word store, read address walk, slot compare and result registers.
// Depends on kss_pkg and kss_ram.
`default_nettype none

module kss_dp
	import kss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire kss_cmd_t              ctl,
	output kss_stat_t                  st,
	input  wire logic [IDX_W-1:0]      word_index,
	input  wire logic [WORD_W-1:0]     write_value,
	input  wire logic [WORD_W-1:0]     key_first,
	input  wire logic [WORD_W-1:0]     key_second,
	input  wire logic [WORD_W-1:0]     key_third,
	output logic                       found,
	output logic                       has_place,
	output logic [SEG_OUT_W-1:0]       segment_number,
	output logic [SLOT_OUT_W-1:0]      slot_number
);

	// captured word
	logic [WORD_W-1:0]  key0_q, key1_q, key2_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [WORD_W-1:0]  wr_val_q;
	logic               wr_ok_q;

	// erase pass
	logic [ADDR_W-1:0]  clr_q;

	// read issue side
	logic [ADDR_W-1:0]  rd_base_q;
	logic [OFF_W-1:0]   rd_off_q;
	logic [SEG_IW-1:0]  rd_seg_q;
	logic [SLOT_IW-1:0] rd_slot_q;
	phase_t             rd_phase_q;
	logic               iss_done_q;

	// word in flight, evaluated when read data returns
	logic               v_s1;
	logic [ADDR_W-1:0]  base_s1;
	logic [SEG_IW-1:0]  seg_s1;
	logic [SLOT_IW-1:0] slot_s1;
	phase_t             phase_s1;

	logic               eq_q, ers_q;
	logic               have_free_q;
	logic [SEG_IW-1:0]  free_seg_q;
	logic [SLOT_IW-1:0] free_slot_q;

	logic               ram_we, ram_re, issue;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [WORD_W-1:0]  ram_wdata, rdata;

	assign issue     = ctl.scan && !ctl.skip && !iss_done_q;
	assign ram_re    = issue;
	assign ram_raddr = rd_base_q + ADDR_W'(rd_off_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_addr_q;
		ram_wdata = wr_val_q;
		if (ctl.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = ERASED_WORD;
		end else if (ctl.write) begin
			ram_we = wr_ok_q;
		end
	end

	kss_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_WORDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_comb begin
		st            = '0;
		st.eval_v     = v_s1;
		st.eval_tag   = (phase_s1 == PH_TAG);
		st.tag_hit    = (rdata == SEGMENT_TAG);
		st.slot_end   = (phase_s1 == PH_W2);
		st.match      = eq_q && (rdata == key2_q);
		st.free_new   = ers_q && (rdata == ERASED_WORD) && !have_free_q;
		st.last_slot  = (slot_s1 == LAST_SLOT);
		st.last_seg   = (seg_s1 == LAST_SEG);
		st.clear_last = (clr_q == LAST_ADDR);
	end

	// payload capture, slot compare and result registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key0_q    <= key_first;
			key1_q    <= key_second;
			key2_q    <= key_third;
			wr_addr_q <= ADDR_W'(word_index);
			wr_val_q  <= write_value;
			wr_ok_q   <= (32'(word_index) < 32'(STORE_WORDS));
		end
		if (v_s1) begin
			unique case (phase_s1)
				PH_W0: begin
					eq_q  <= (rdata == key0_q);
					ers_q <= (rdata == ERASED_WORD);
				end
				PH_W1: begin
					eq_q  <= eq_q && (rdata == key1_q);
					ers_q <= ers_q && (rdata == ERASED_WORD);
				end
				default: begin
				end
			endcase
		end
		if (ctl.record) begin
			free_seg_q  <= seg_s1;
			free_slot_q <= slot_s1;
		end
		base_s1  <= rd_base_q;
		seg_s1   <= rd_seg_q;
		slot_s1  <= rd_slot_q;
		phase_s1 <= rd_phase_q;
		if (ctl.finish) begin
			case (ctl.kind)
				RES_FOUND: begin
					found          <= 1'b1;
					has_place      <= 1'b0;
					segment_number <= SEG_OUT_W'(seg_s1);
					slot_number    <= SLOT_OUT_W'(slot_s1);
				end
				RES_END: begin
					found <= 1'b0;
					if (ctl.record) begin
						has_place      <= 1'b1;
						segment_number <= SEG_OUT_W'(seg_s1);
						slot_number    <= SLOT_OUT_W'(slot_s1);
					end else if (have_free_q) begin
						has_place      <= 1'b1;
						segment_number <= SEG_OUT_W'(free_seg_q);
						slot_number    <= SLOT_OUT_W'(free_slot_q);
					end else begin
						has_place      <= 1'b0;
						segment_number <= '0;
						slot_number    <= '0;
					end
				end
				default: begin
					found          <= 1'b0;
					has_place      <= 1'b0;
					segment_number <= '0;
					slot_number    <= '0;
				end
			endcase
		end
	end

	// control state of the erase pass and the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rd_base_q   <= '0;
			rd_off_q    <= '0;
			rd_seg_q    <= '0;
			rd_slot_q   <= '0;
			rd_phase_q  <= PH_TAG;
			iss_done_q  <= 1'b0;
			v_s1        <= 1'b0;
			have_free_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			v_s1 <= issue;
			if (ctl.record) begin
				have_free_q <= 1'b1;
			end
			if (ctl.load) begin
				rd_base_q   <= '0;
				rd_off_q    <= '0;
				rd_seg_q    <= '0;
				rd_slot_q   <= '0;
				rd_phase_q  <= PH_TAG;
				iss_done_q  <= 1'b0;
				have_free_q <= 1'b0;
			end else if (ctl.skip) begin
				// resume at the tag of the segment after the evaluated one
				rd_base_q  <= base_s1 + SEG_STRIDE;
				rd_off_q   <= '0;
				rd_seg_q   <= seg_s1 + 1'b1;
				rd_slot_q  <= '0;
				rd_phase_q <= PH_TAG;
				iss_done_q <= 1'b0;
			end else if (issue) begin
				unique case (rd_phase_q)
					PH_TAG: begin
						rd_phase_q <= PH_W0;
						rd_off_q   <= OFF_W'(1);
						rd_slot_q  <= '0;
					end
					PH_W0: begin
						rd_phase_q <= PH_W1;
						rd_off_q   <= rd_off_q + 1'b1;
					end
					PH_W1: begin
						rd_phase_q <= PH_W2;
						rd_off_q   <= rd_off_q + 1'b1;
					end
					PH_W2: begin
						if (rd_slot_q == LAST_SLOT) begin
							if (rd_seg_q == LAST_SEG) begin
								iss_done_q <= 1'b1;
							end else begin
								rd_base_q  <= rd_base_q + SEG_STRIDE;
								rd_seg_q   <= rd_seg_q + 1'b1;
								rd_off_q   <= '0;
								rd_phase_q <= PH_TAG;
							end
						end else begin
							rd_slot_q  <= rd_slot_q + 1'b1;
							rd_off_q   <= rd_off_q + 1'b1;
							rd_phase_q <= PH_W0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire
